### rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// shared widths, opcodes, command types for the mse loss/gradient unit
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned DataW = 32;  // q16.16 element width
  localparam int unsigned CfgW  = 21;  // element count register width
  localparam int unsigned SumW  = 64;  // square sum width

  // request opcodes
  localparam logic OP_FWD = 1'b0;
  localparam logic OP_BWD = 1'b1;

  // result kinds
  localparam logic RES_LOSS = 1'b0;
  localparam logic RES_GRAD = 1'b1;

  // classified work handed from front to back
  typedef enum logic [1:0] {
    CMD_ACC  = 2'd0,  // forward element, sum only
    CMD_LAST = 2'd1,  // forward element that closes the tensor
    CMD_GRAD = 2'd2   // backward element
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [DataW-1:0]   d_mag;   // |a - b|
    logic [DataW-1:0]   g_mag;   // |g| for backward, |a - b| for forward
    logic               neg;     // sign of g*(a-b)
    logic [DataW-1:0]   grad_a;
    logic [DataW-1:0]   grad_b;
  } cmd_t;

endpackage

### rtl/core/mse_in_if.sv
// ----------------------------------------------------------------------------
// mse_in_if
// element request channel: one prediction/target pair plus gradients
// ----------------------------------------------------------------------------
interface mse_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [mse_pkg::DataW-1:0]  a_value;
  logic signed [mse_pkg::DataW-1:0]  b_value;
  logic signed [mse_pkg::DataW-1:0]  upstream_grad;
  logic signed [mse_pkg::DataW-1:0]  grad_a_in;
  logic signed [mse_pkg::DataW-1:0]  grad_b_in;

  modport source (
    output valid, opcode, a_value, b_value, upstream_grad, grad_a_in, grad_b_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_value, b_value, upstream_grad, grad_a_in, grad_b_in,
    output ready
  );
endinterface

### rtl/core/mse_out_if.sv
// ----------------------------------------------------------------------------
// mse_out_if
// result channel: loss or updated gradient pair
// ----------------------------------------------------------------------------
interface mse_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic        [mse_pkg::DataW-1:0]  loss_value;
  logic signed [mse_pkg::DataW-1:0]  new_grad_a;
  logic signed [mse_pkg::DataW-1:0]  new_grad_b;

  modport source (
    output valid, result_kind, loss_value, new_grad_a, new_grad_b,
    input  ready
  );
  modport sink (
    input  valid, result_kind, loss_value, new_grad_a, new_grad_b,
    output ready
  );
endinterface

### rtl/core/mse_cfg_if.sv
// ----------------------------------------------------------------------------
// mse_cfg_if
// configuration write channel for the element count register
// ----------------------------------------------------------------------------
interface mse_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mse_pkg::CfgW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/mse_loss_forward_backward_unit.sv
// ----------------------------------------------------------------------------
// mse_loss_forward_backward_unit
// streamed mean squared error loss (forward) and gradient update (backward)
// ----------------------------------------------------------------------------
//
//  channel   dir   modport   carries
//  -------   ---   -------   ---------------------------------------------
//  in_i      in    sink      opcode, a/b values, upstream grad, grad a/b in
//  cfg_i     in    sink      element count (divisor n)
//  out_o     out   source    result kind, loss value, new grad a/b
//
//  forward elements that only accumulate retire at one per cycle while the
//  back is not dividing or holding a result; the queue and product register
//  lie before the sum. loss-emitting and backward elements go through the
//  bit-serial divider that produces one quotient bit per cycle
//  reset (async, active low) clears the sum, the element counter, the queue
//  and the result valid flag; the element count returns to 1
//  a 2-entry command queue lets the front keep accepting while the back
//  divides, and the result register lets the back finish while out_o stalls
//
module mse_loss_forward_backward_unit #(
  parameter int unsigned COUNT_BITS  = 20,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mse_in_if.sink      in_i,
  mse_cfg_if.sink     cfg_i,
  mse_out_if.source   out_o
);

  localparam int unsigned NumW = mse_pkg::SumW - FRAC_BITS;

  // front to queue
  logic                       cmd_push, cmd_full;
  mse_pkg::cmd_t              cmd_in;
  // queue to back
  logic                       cmd_pop, cmd_empty;
  mse_pkg::cmd_t              cmd_head;
  // element count, held by the front
  logic [mse_pkg::CfgW-1:0]   elem_count;
  // back to divider
  logic                       div_start, div_busy, div_done;
  logic [NumW-1:0]            div_num, div_quo;
  logic [mse_pkg::CfgW-1:0]   div_den;

  // request intake, counter and classification
  mse_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (cmd_full),
    .push_o   (cmd_push),
    .cmd_o    (cmd_in),
    .count_o  (elem_count)
  );

  // decoupling queue
  mse_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  // shared divider for loss mean and gradient scaling
  mse_div #(
    .NUM_W (NumW),
    .DEN_W (mse_pkg::CfgW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // multiply-accumulate, result shaping, output register
  mse_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (cmd_empty),
    .q_cmd_i     (cmd_head),
    .pop_o       (cmd_pop),
    .count_i     (elem_count),
    .div_start_o (div_start),
    .div_num_o   (div_num),
    .div_den_o   (div_den),
    .div_done_i  (div_done),
    .div_quo_i   (div_quo),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // front must never push into a full queue
  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("push into full command queue");

  // back must never pop an empty queue
  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("pop from empty command queue");

  // a new division only starts once the divider is free
  a_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // a loss result carries zero gradients
  a_loss_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == mse_pkg::RES_LOSS) |->
      (out_o.new_grad_a == '0 && out_o.new_grad_b == '0))
    else $error("loss result with nonzero gradient fields");
`endif

endmodule

### rtl/core/mse_front.sv
// ----------------------------------------------------------------------------
// mse_front
// accepts element requests, holds the element count, classifies each request
// ----------------------------------------------------------------------------
module mse_front #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mse_in_if.sink                     in_i,
  mse_cfg_if.sink                    cfg_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output mse_pkg::cmd_t              cmd_o,
  output logic [mse_pkg::CfgW-1:0]   count_o
);

  localparam logic [32:0] CountCap = 33'(1) << COUNT_BITS;

  logic [mse_pkg::CfgW-1:0]  n_q, n_d;
  logic [mse_pkg::CfgW-1:0]  seen_q, seen_d, seen_inc;
  logic [32:0]               diff, d_abs, g_ext, g_abs;
  logic                      last;

  // count register stores the effective divisor
  assign cfg_i.ready = 1'b1;

  always_comb begin
    n_d = n_q;
    if (cfg_i.valid) begin
      if (cfg_i.data == '0) begin
        n_d = mse_pkg::CfgW'(1);
      end else if ({12'b0, cfg_i.data} > CountCap) begin
        n_d = CountCap[mse_pkg::CfgW-1:0];
      end else begin
        n_d = cfg_i.data;
      end
    end
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  // magnitudes and product sign
  assign diff  = {in_i.a_value[31], in_i.a_value} - {in_i.b_value[31], in_i.b_value};
  assign d_abs = diff[32] ? (33'd0 - diff) : diff;
  assign g_ext = {in_i.upstream_grad[31], in_i.upstream_grad};
  assign g_abs = g_ext[32] ? (33'd0 - g_ext) : g_ext;

  assign seen_inc = seen_q + mse_pkg::CfgW'(1);
  assign last     = seen_inc >= n_q;

  always_comb begin
    cmd_o.d_mag  = d_abs[31:0];
    cmd_o.neg    = (in_i.upstream_grad[31] != diff[32]) &&
                   (in_i.upstream_grad != '0) && (diff != '0);
    cmd_o.grad_a = in_i.grad_a_in;
    cmd_o.grad_b = in_i.grad_b_in;
    if (in_i.opcode == mse_pkg::OP_BWD) begin
      cmd_o.kind  = mse_pkg::CMD_GRAD;
      cmd_o.g_mag = g_abs[31:0];
    end else begin
      cmd_o.kind  = last ? mse_pkg::CMD_LAST : mse_pkg::CMD_ACC;
      cmd_o.g_mag = d_abs[31:0];
    end
  end

  always_comb begin
    seen_d = seen_q;
    if (push_o && in_i.opcode == mse_pkg::OP_FWD) begin
      seen_d = last ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= mse_pkg::CfgW'(1);
      seen_q <= '0;
    end else begin
      n_q    <= n_d;
      seen_q <= seen_d;
    end
  end

  assign count_o = n_q;

endmodule

### rtl/core/mse_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mse_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module mse_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mse_pkg::cmd_t   cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output mse_pkg::cmd_t   cmd_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mse_pkg::cmd_t    mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      2'b11:   cnt_d = cnt_q;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o   = mem_q[rd_ptr_q];
  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;

endmodule

### rtl/core/mse_div.sv
// ----------------------------------------------------------------------------
// mse_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mse_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [NUM_W-1:0]  quo_o
);

  localparam int unsigned CntW = $clog2(NUM_W);

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  num_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    shifted, trial;
  logic              fits;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and shifting dividend/quotient word
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      num_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

### rtl/core/mse_back.sv
// ----------------------------------------------------------------------------
// mse_back
// multiply, accumulate, divide and result register
// ----------------------------------------------------------------------------
module mse_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_empty_i,
  input  mse_pkg::cmd_t                          q_cmd_i,
  output logic                                   pop_o,
  input  logic [mse_pkg::CfgW-1:0]               count_i,
  output logic                                   div_start_o,
  output logic [mse_pkg::SumW-FRAC_BITS-1:0]     div_num_o,
  output logic [mse_pkg::CfgW-1:0]               div_den_o,
  input  logic                                   div_done_i,
  input  logic [mse_pkg::SumW-FRAC_BITS-1:0]     div_quo_i,
  mse_out_if.source                              out_o
);

  localparam int unsigned NumW = mse_pkg::SumW - FRAC_BITS;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_RES = 3'b100
  } back_state_e;

  function automatic logic [31:0] sat32(input logic [36:0] v);
    logic [31:0] r;
    if (!v[36] && (v[35:31] != 5'b00000)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[36] && (v[35:31] != 5'b11111)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  back_state_e          state_q, state_d;
  logic                 prod_valid_q, prod_valid_d;
  logic [63:0]          prod_q, mul;
  mse_pkg::cmd_kind_e   kind_q;
  logic                 neg_q;
  logic [31:0]          ga_q, gb_q;
  logic [63:0]          sum_q, sum_d, sum_sat, prod_x2;
  logic [64:0]          sum_wide;
  logic                 out_valid_q, out_free, out_load;
  logic [31:0]          loss_sat;
  logic                 amt_over;
  logic [34:0]          amt;
  logic [35:0]          delta;
  logic [36:0]          sum_a, sum_b;

  assign sum_wide = {1'b0, sum_q} + {1'b0, prod_q};
  assign sum_sat  = sum_wide[64] ? '1 : sum_wide[63:0];
  assign prod_x2  = {prod_q[62:0], 1'b0};
  // 32 x 32 product, operands zero-extended to the full result width
  assign mul      = {32'b0, q_cmd_i.d_mag} * {32'b0, q_cmd_i.g_mag};
  assign out_free = !out_valid_q || out_o.ready;

  // result shaping from quotient
  assign loss_sat = (div_quo_i[NumW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo_i[31:0];
  assign amt_over = (div_quo_i[NumW-1:35] != '0) || (div_quo_i[34] && (div_quo_i[33:0] != '0));
  assign amt      = amt_over ? (35'd1 << 34) : div_quo_i[34:0];
  assign delta    = neg_q ? (36'd0 - {1'b0, amt}) : {1'b0, amt};
  assign sum_a    = {{5{ga_q[31]}}, ga_q} + {delta[35], delta};
  assign sum_b    = {{5{gb_q[31]}}, gb_q} - {delta[35], delta};

  assign div_num_o = (kind_q == mse_pkg::CMD_LAST) ? sum_sat[63:FRAC_BITS]
                                                   : prod_x2[63:FRAC_BITS];
  assign div_den_o = count_i;

  always_comb begin
    state_d      = state_q;
    prod_valid_d = prod_valid_q;
    sum_d        = sum_q;
    pop_o        = 1'b0;
    div_start_o  = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (prod_valid_q) begin
          unique case (kind_q)
            mse_pkg::CMD_ACC: begin
              sum_d        = sum_sat;
              prod_valid_d = 1'b0;
            end
            mse_pkg::CMD_LAST: begin
              sum_d       = '0;
              div_start_o = 1'b1;
              state_d     = ST_DIV;
            end
            mse_pkg::CMD_GRAD: begin
              div_start_o = 1'b1;
              state_d     = ST_DIV;
            end
            default: prod_valid_d = 1'b0;
          endcase
        end
        // accumulate-only products retire here, so the next pair can follow
        if (!q_empty_i && (!prod_valid_q || kind_q == mse_pkg::CMD_ACC)) begin
          pop_o        = 1'b1;
          prod_valid_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done_i) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_load     = 1'b1;
          prod_valid_d = 1'b0;
          state_d      = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      prod_valid_q <= 1'b0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prod_valid_q <= prod_valid_d;
      sum_q        <= sum_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q <= mul;
      kind_q <= q_cmd_i.kind;
      neg_q  <= q_cmd_i.neg;
      ga_q   <= q_cmd_i.grad_a;
      gb_q   <= q_cmd_i.grad_b;
    end
    if (out_load) begin
      if (kind_q == mse_pkg::CMD_LAST) begin
        out_o.result_kind <= mse_pkg::RES_LOSS;
        out_o.loss_value  <= loss_sat;
        out_o.new_grad_a  <= '0;
        out_o.new_grad_b  <= '0;
      end else begin
        out_o.result_kind <= mse_pkg::RES_GRAD;
        out_o.loss_value  <= '0;
        out_o.new_grad_a  <= sat32(sum_a);
        out_o.new_grad_b  <= sat32(sum_b);
      end
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
